>>> design/sle_pkg.sv
package sle_pkg;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // request word
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
    logic [9:0]         position;
  } req_t;

  // response word
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [10:0]        entry_count;
  } rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

>>> design/sle_chan_if.sv
interface sle_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/sle_cell.sv
module sle_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  sle_pkg::cell_ctrl_t    ctrl,
  input  logic [VALUE_WIDTH-1:0] ins_value,
  input  logic                   occupied,
  input  logic                   at_or_past_pos,
  input  logic                   left_take,
  input  logic [VALUE_WIDTH-1:0] left_entry,
  input  logic [VALUE_WIDTH-1:0] right_entry,
  output logic                   take,
  output logic [VALUE_WIDTH-1:0] entry
);
  import sle_pkg::*;

  logic [VALUE_WIDTH-1:0] entry_next;

  // insert point is at or before this cell: empty slot or stored entry >= new value
  assign take = !occupied || ($signed(entry) >= $signed(ins_value));

  // shift right behind the insert point, shift left from the removed slot
  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (left_take) begin
        entry_next = left_entry;
      end else if (take) begin
        entry_next = ins_value;
      end
    end else if (ctrl.rem && at_or_past_pos) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> design/sorted_list_engine_top.sv
// A word's response is registered on the clock edge that accepts the request.
// Throughput: 1 word per cycle while the response register frees up; every cell updates in parallel in that cycle.
// Requests are taken while a response waits, as long as the response register frees up.
// Reset (rst, synchronous): entry count cleared, no response pending.
// Entry contents are not cleared; only positions below the count are ever read.
module sorted_list_engine_top #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  sle_chan_if.sink   req,
  sle_chan_if.source rsp
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   rsp_valid;
  rsp_t                   rsp_data;
  rsp_t                   rsp_data_next;

  logic                   accept;
  logic                   full;
  logic                   pos_ok;
  logic [63:0]            value_ext;
  logic [VALUE_WIDTH-1:0] ins_value;
  logic [63:0]            rd_ext;
  cell_ctrl_t             ctrl;

  logic [VALUE_WIDTH-1:0] entry [CAPACITY];
  logic                   take  [CAPACITY];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // decode
  assign full      = (count == CW'(CAPACITY));
  assign pos_ok    = (32'(req.data.position) < 32'(count));
  assign value_ext = 64'(req.data.value);
  assign ins_value = value_ext[VALUE_WIDTH-1:0];
  assign ctrl.ins  = accept && (req.data.action == ACT_INSERT) && !full;
  assign ctrl.rem  = accept && (req.data.action == ACT_REMOVE) && pos_ok;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   occ;
    logic                   past;
    logic                   lt;
    logic [VALUE_WIDTH-1:0] le;
    logic [VALUE_WIDTH-1:0] re;

    assign occ  = (32'(i) < 32'(count));
    assign past = (32'(i) >= 32'(req.data.position));
    if (i == 0) begin : g_first
      assign lt = 1'b0;
      assign le = entry[i];
    end else begin : g_mid
      assign lt = take[i-1];
      assign le = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign re = entry[i];
    end else begin : g_body
      assign re = entry[i+1];
    end

    sle_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .ins_value      (ins_value),
      .occupied       (occ),
      .at_or_past_pos (past),
      .left_take      (lt),
      .left_entry     (le),
      .right_entry    (re),
      .take           (take[i]),
      .entry          (entry[i])
    );
  end

  // read selection, sign-extended to the output width
  assign rd_ext = 64'($signed(entry[req.data.position[IW-1:0]]));

  // response and count
  always_comb begin
    count_next                = count;
    rsp_data_next.read_value  = '0;
    rsp_data_next.status      = ST_DONE;
    unique case (req.data.action)
      ACT_INSERT: begin
        if (full) begin
          rsp_data_next.status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      ACT_READ: begin
        if (pos_ok) begin
          rsp_data_next.read_value = rd_ext[31:0];
        end else begin
          rsp_data_next.status = ST_RANGE;
        end
      end
      ACT_REMOVE: begin
        if (pos_ok) begin
          count_next = count - CW'(1);
        end else begin
          rsp_data_next.status = ST_RANGE;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_data_next.entry_count = 11'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= rsp_data_next;
    end
  end

endmodule

>>> tb/sle_list_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the sorted list engine, keeps its own copy of
// the list and compares every response word against the predicted one.
module sle_list_checker
  import sle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_word,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_word,
  output int   fail_count,
  output int   owed_count,
  output int   checked,
  output int   full_hits,
  output int   range_hits
);

  // shadow list, ascending, valid below list_len
  logic signed [31:0] list_vals [CAPACITY];
  int                 list_len;

  // responses predicted but not yet seen
  rsp_t owed_rsps [$];

  // Apply one request word to the shadow list, return the response it causes
  function automatic rsp_t apply_to_list(req_t w);
    rsp_t r;
    int   at;
    int   i;
    bit   found;
    r     = '0;
    found = 1'b0;
    case (w.action)
      ACT_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // first entry >= new value; equals end up behind the new one
          at = list_len;
          for (i = 0; i < list_len; i++) begin
            if (!found && $signed(list_vals[i]) >= $signed(w.value)) begin
              at    = i;
              found = 1'b1;
            end
          end
          for (i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = w.value;
          list_len++;
          r.status = ST_DONE;
        end
      end
      ACT_READ: begin
        if (int'(w.position) >= list_len) r.status = ST_RANGE;
        else r.read_value = list_vals[w.position];
      end
      ACT_REMOVE: begin
        if (int'(w.position) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = w.position; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: r.status = ST_DONE;  // unused action code: no effect
    endcase
    r.entry_count = list_len[10:0];
    return r;
  endfunction

  // Compare on response handshake, predict on request handshake
  always @(posedge clk) begin : watch
    rsp_t exp_rsp;
    if (rst) begin
      list_len   = 0;
      fail_count = 0;
      checked    = 0;
      full_hits  = 0;
      range_hits = 0;
      owed_rsps.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_rsps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected response word: value %0d status %0d count %0d",
                     $realtime, rsp_word.read_value, rsp_word.status, rsp_word.entry_count);
        end else begin
          exp_rsp = owed_rsps.pop_front();
          checked++;
          if (exp_rsp.status == ST_FULL) full_hits++;
          if (exp_rsp.status == ST_RANGE) range_hits++;
          if (rsp_word.read_value !== exp_rsp.read_value ||
              rsp_word.status !== exp_rsp.status ||
              rsp_word.entry_count !== exp_rsp.entry_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch: expected value %0d status %0d count %0d, ",
                        "got value %0d status %0d count %0d"},
                       $realtime, exp_rsp.read_value, exp_rsp.status, exp_rsp.entry_count,
                       rsp_word.read_value, rsp_word.status, rsp_word.entry_count);
          end
        end
      end
      if (req_valid && req_ready) owed_rsps.push_back(apply_to_list(req_word));
    end
    // seen by the stimulus through a register, which is deterministic
    owed_count <= owed_rsps.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sle_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int PHASE_WORDS = 542;

  // action code with no meaning to the block
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst;

  int fail_count;
  int owed_count;
  int checked;
  int full_hits;
  int range_hits;

  int idle_pct;
  int stall_pct;
  int n_insert;
  int n_read;
  int n_remove;
  int n_unused;

  sle_chan_if #(.payload_t(req_t)) req_ch ();
  sle_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  sorted_list_engine_top #(
    .CAPACITY(CAPACITY),
    .VALUE_WIDTH(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  sle_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_chk (
    .clk(clk),
    .rst(rst),
    .req_valid(req_ch.valid),
    .req_ready(req_ch.ready),
    .req_word(req_ch.data),
    .rsp_valid(rsp_ch.valid),
    .rsp_ready(rsp_ch.ready),
    .rsp_word(rsp_ch.data),
    .fail_count(fail_count),
    .owed_count(owed_count),
    .checked(checked),
    .full_hits(full_hits),
    .range_hits(range_hits)
  );

  always #1 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // hard stop
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Drive one request word and hold it until the block takes it
  task automatic send(input logic [1:0] act, input logic signed [31:0] val,
                      input logic [9:0] pos);
    req_t w;
    w.action   = act;
    w.value    = val;
    w.position = pos;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    case (act)
      ACT_INSERT: n_insert++;
      ACT_READ:   n_read++;
      ACT_REMOVE: n_remove++;
      default:    n_unused++;
    endcase
  endtask

  // Stop sending until every outstanding response has come back
  task automatic drain_pause();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
  endtask

  // small values give many duplicates, extremes hit the sign boundary
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $signed($urandom_range(0, 8)) - 4;
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_MIN + 1;
        default: return VAL_MAX - 1;
      endcase
    end
    return $urandom;
  endfunction

  // mostly near the live range of the list, sometimes anywhere
  function automatic logic [9:0] pick_position();
    if ($urandom_range(0, 99) < 85) return 10'($urandom_range(0, CAPACITY + 1));
    return 10'($urandom_range(0, 1023));
  endfunction

  // Random words: stretches that each lean, by random choice, toward filling or draining
  task automatic random_phase();
    int         n;
    int         r;
    bit         filling;
    logic [1:0] act;
    filling = 1'b1;
    for (n = 0; n < PHASE_WORDS; n++) begin
      if (n % 40 == 0) filling = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (filling) act = (r < 55) ? ACT_INSERT : (r < 75) ? ACT_READ :
                         (r < 97) ? ACT_REMOVE : ACT_UNUSED;
      else act = (r < 20) ? ACT_INSERT : (r < 45) ? ACT_READ :
                 (r < 97) ? ACT_REMOVE : ACT_UNUSED;
      if (n == PHASE_WORDS / 2 && stall_pct != 0) drain_pause();
      send(act, pick_value(), pick_position());
    end
    drain_pause();
  endtask

  initial begin
    int i;
    int g;
    n_insert  = 0;
    n_read    = 0;
    n_remove  = 0;
    n_unused  = 0;
    idle_pct  = 32;
    stall_pct = 77;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    rst          <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty list: out of range, unused action
    send(ACT_READ, 32'sd7, 10'd0);
    send(ACT_REMOVE, 32'sd0, 10'd1023);
    send(ACT_UNUSED, VAL_MIN, 10'd0);
    // extremes, equal values, a value past the end
    send(ACT_INSERT, 32'sd0, 10'd1023);
    send(ACT_INSERT, VAL_MAX, 10'd0);
    send(ACT_INSERT, VAL_MIN, 10'd0);
    send(ACT_INSERT, 32'sd0, 10'd0);
    send(ACT_INSERT, -32'sd1, 10'd0);
    send(ACT_INSERT, VAL_MAX, 10'd0);
    send(ACT_READ, 32'sd0, 10'd0);
    send(ACT_READ, 32'sd0, 10'd5);
    send(ACT_READ, 32'sd0, 10'd6);
    // fill to capacity, then one more is dropped
    for (i = 0; i < CAPACITY - 6; i++) send(ACT_INSERT, pick_value(), 10'd0);
    send(ACT_INSERT, 32'sd1, 10'd0);
    send(ACT_READ, -32'sd1, 10'd15);
    send(ACT_REMOVE, 32'sd0, 10'd0);
    send(ACT_REMOVE, 32'sd0, 10'd15);
    send(ACT_REMOVE, 32'sd0, 10'd14);
    drain_pause();

    random_phase();
    idle_pct  = 77;
    stall_pct = 32;
    random_phase();
    idle_pct  = 0;
    stall_pct = 0;
    random_phase();

    // wait out the remaining responses plus the response register
    req_ch.valid <= 1'b0;
    for (g = 0; g < 20000 && owed_count != 0; g++) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d words: %0d inserts, %0d reads, %0d removes, %0d unused codes.",
             n_insert + n_read + n_remove + n_unused, n_insert, n_read, n_remove, n_unused);
    $display("%0d responses compared; full list %0d times, position out of range %0d times.",
             checked, full_hits, range_hits);
    if (fail_count == 0 && owed_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sle_pkg.sv
design/sle_chan_if.sv
design/sle_cell.sv
design/sorted_list_engine_top.sv
tb/sle_list_checker.sv
tb/tb_top.sv
